// ===== sv/urs_pkg.sv =====
// Shared types and constants for the ultrasonic ranging sequencer.
// Used by urs_regs, urs_core and the top level; depends on nothing else.
`default_nettype none
package urs_pkg;

  // Sequencer phases, one-hot.
  typedef enum logic [4:0] {
    PH_IDLE      = 5'b00001,
    PH_WAIT_LOW  = 5'b00010,
    PH_TRIG_LOW  = 5'b00100,
    PH_TRIG_HIGH = 5'b01000,
    PH_WAIT_ECHO = 5'b10000
  } phase_t;

  // Measurement status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_STUCK    = 3'd1;
  localparam logic [2:0] ST_TIMEOUT  = 3'd2;
  localparam logic [2:0] ST_TOO_NEAR = 3'd3;
  localparam logic [2:0] ST_TOO_FAR  = 3'd4;

  // Register indexes (byte address divided by four).
  localparam logic [2:0] REG_ECHO_LOW_WAIT = 3'd0;
  localparam logic [2:0] REG_TRIG_LOW      = 3'd1;
  localparam logic [2:0] REG_TRIG_HIGH     = 3'd2;
  localparam logic [2:0] REG_ECHO_WAIT     = 3'd3;
  localparam logic [2:0] REG_SOUND_SPEED   = 3'd4;
  localparam logic [2:0] REG_MIN_RANGE     = 3'd5;
  localparam logic [2:0] REG_MAX_RANGE     = 3'd6;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  typedef struct packed {
    logic [15:0] echo_low_wait_limit;
    logic [7:0]  trigger_low_time;
    logic [7:0]  trigger_high_time;
    logic [15:0] echo_wait_limit;
    logic [15:0] sound_speed_q16;
    logic [11:0] min_range_cm;
    logic [11:0] max_range_cm;
  } cfg_t;

  typedef struct packed {
    logic        trigger_level;
    logic        busy_res;
    logic        done_res;
    logic [2:0]  status;
    logic [15:0] pulse_width_us;
    logic [15:0] distance_q4;
  } res_t;

endpackage
`default_nettype wire

// ===== sv/urs_regs.sv =====
// Configuration register file with an APB-style write/read port.
// Depends on urs_pkg for the register indexes and the cfg_t layout.
`default_nettype none
module urs_regs (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [urs_pkg::ADDR_W-1:0] paddr,
  input  wire logic [urs_pkg::DATA_W-1:0] pwdata,
  output logic      [urs_pkg::DATA_W-1:0] prdata,
  output logic                           pready,
  output urs_pkg::cfg_t                  cfg_o
);

  urs_pkg::cfg_t cfg_r;
  urs_pkg::cfg_t cfg_nxt;
  logic [2:0]    idx;
  logic          wr_en;

  assign idx    = paddr[4:2];
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg_o  = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        urs_pkg::REG_ECHO_LOW_WAIT: cfg_nxt.echo_low_wait_limit = pwdata[15:0];
        urs_pkg::REG_TRIG_LOW:      cfg_nxt.trigger_low_time    = pwdata[7:0];
        urs_pkg::REG_TRIG_HIGH:     cfg_nxt.trigger_high_time   = pwdata[7:0];
        urs_pkg::REG_ECHO_WAIT:     cfg_nxt.echo_wait_limit     = pwdata[15:0];
        urs_pkg::REG_SOUND_SPEED:   cfg_nxt.sound_speed_q16     = pwdata[15:0];
        urs_pkg::REG_MIN_RANGE:     cfg_nxt.min_range_cm        = pwdata[11:0];
        urs_pkg::REG_MAX_RANGE:     cfg_nxt.max_range_cm        = pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      urs_pkg::REG_ECHO_LOW_WAIT: prdata = {16'd0, cfg_r.echo_low_wait_limit};
      urs_pkg::REG_TRIG_LOW:      prdata = {24'd0, cfg_r.trigger_low_time};
      urs_pkg::REG_TRIG_HIGH:     prdata = {24'd0, cfg_r.trigger_high_time};
      urs_pkg::REG_ECHO_WAIT:     prdata = {16'd0, cfg_r.echo_wait_limit};
      urs_pkg::REG_SOUND_SPEED:   prdata = {16'd0, cfg_r.sound_speed_q16};
      urs_pkg::REG_MIN_RANGE:     prdata = {20'd0, cfg_r.min_range_cm};
      urs_pkg::REG_MAX_RANGE:     prdata = {20'd0, cfg_r.max_range_cm};
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.echo_low_wait_limit <= 16'd30000;
      cfg_r.trigger_low_time    <= 8'd2;
      cfg_r.trigger_high_time   <= 8'd20;
      cfg_r.echo_wait_limit     <= 16'd30000;
      cfg_r.sound_speed_q16     <= 16'd2248;
      cfg_r.min_range_cm        <= 12'd25;
      cfg_r.max_range_cm        <= 12'd450;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/urs_core.sv =====
// Ranging sequencer state and per-tick step logic: phase machine, saturating
// counters, width-to-distance product and classification. Depends on urs_pkg.
`default_nettype none
module urs_core #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step_i,
  input  wire logic          start_i,
  input  wire logic          echo_i,
  input  wire urs_pkg::cfg_t cfg_i,
  output urs_pkg::res_t      res_o
);

  localparam int CW  = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam int PW  = COUNT_BITS + 16;
  localparam int PCW = (PW > 29) ? PW : 29;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  urs_pkg::phase_t         phase_r, phase_nxt;
  logic [COUNT_BITS-1:0]   phase_timer_r, phase_timer_nxt;
  logic [COUNT_BITS-1:0]   since_trigger_r, since_trigger_nxt;
  logic [COUNT_BITS-1:0]   width_count_r, width_count_nxt;
  logic                    echo_seen_r, echo_seen_nxt;

  logic [PW-1:0]           prod;
  logic [PCW-1:0]          prod_e;
  logic [PCW-1:0]          dist_full;
  logic [15:0]             dist_sat;
  logic [15:0]             pw_sat;
  logic [2:0]              range_status;

  function automatic logic [COUNT_BITS-1:0] count_up(input logic [COUNT_BITS-1:0] v);
    return (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
  endfunction

  // A counter pinned at its maximum counts as expired whatever the limit.
  function automatic logic expired(input logic [COUNT_BITS-1:0] v, input logic [15:0] lim);
    logic [CW-1:0] ve;
    logic [CW-1:0] le;
    ve = CW'(v);
    le = CW'(lim);
    return (ve >= le) || (v == CNT_MAX);
  endfunction

  // The finishing tick has echo low, so the stored width is the final width.
  assign prod      = PW'(width_count_r) * PW'(cfg_i.sound_speed_q16);
  assign prod_e    = PCW'(prod);
  assign dist_full = prod_e >> 13;
  assign dist_sat  = (dist_full > PCW'(16'hFFFF)) ? 16'hFFFF : dist_full[15:0];
  assign pw_sat    = (CW'(width_count_r) > CW'(16'hFFFF)) ? 16'hFFFF
                                                          : 16'(CW'(width_count_r));

  always_comb begin
    if (prod_e < (PCW'(cfg_i.min_range_cm) << 17)) begin
      range_status = urs_pkg::ST_TOO_NEAR;
    end else if (prod_e > (PCW'(cfg_i.max_range_cm) << 17)) begin
      range_status = urs_pkg::ST_TOO_FAR;
    end else begin
      range_status = urs_pkg::ST_OK;
    end
  end

  always_comb begin
    phase_nxt         = phase_r;
    phase_timer_nxt   = phase_timer_r;
    since_trigger_nxt = since_trigger_r;
    width_count_nxt   = width_count_r;
    echo_seen_nxt     = echo_seen_r;
    res_o             = '0;

    // The tick that takes the start request is also the first echo-low sample.
    if (phase_r == urs_pkg::PH_IDLE && start_i) begin
      phase_nxt       = urs_pkg::PH_WAIT_LOW;
      phase_timer_nxt = '0;
    end

    case (phase_nxt)
      urs_pkg::PH_IDLE: ;
      urs_pkg::PH_WAIT_LOW: begin
        if (!echo_i) begin
          phase_timer_nxt = '0;
          phase_nxt = (cfg_i.trigger_low_time != 8'd0) ? urs_pkg::PH_TRIG_LOW
                                                       : urs_pkg::PH_TRIG_HIGH;
        end else begin
          phase_timer_nxt = count_up(phase_timer_nxt);
          if (expired(phase_timer_nxt, cfg_i.echo_low_wait_limit)) begin
            res_o.done_res = 1'b1;
            res_o.status   = urs_pkg::ST_STUCK;
            phase_nxt      = urs_pkg::PH_IDLE;
          end
        end
      end
      urs_pkg::PH_TRIG_LOW: begin
        phase_timer_nxt = count_up(phase_timer_nxt);
        if (expired(phase_timer_nxt, {8'd0, cfg_i.trigger_low_time})) begin
          phase_timer_nxt = '0;
          phase_nxt       = urs_pkg::PH_TRIG_HIGH;
        end
      end
      urs_pkg::PH_TRIG_HIGH: begin
        res_o.trigger_level = 1'b1;
        phase_timer_nxt     = count_up(phase_timer_nxt);
        if (expired(phase_timer_nxt, {8'd0, cfg_i.trigger_high_time})) begin
          phase_timer_nxt   = '0;
          since_trigger_nxt = '0;
          width_count_nxt   = '0;
          echo_seen_nxt     = 1'b0;
          phase_nxt         = urs_pkg::PH_WAIT_ECHO;
        end
      end
      urs_pkg::PH_WAIT_ECHO: begin
        since_trigger_nxt = count_up(since_trigger_r);
        if (echo_i) begin
          echo_seen_nxt   = 1'b1;
          width_count_nxt = count_up(width_count_r);
        end
        // The falling edge of the echo wins over a timeout on the same tick.
        if (!echo_i && echo_seen_r) begin
          res_o.done_res       = 1'b1;
          res_o.pulse_width_us = pw_sat;
          res_o.distance_q4    = dist_sat;
          res_o.status         = range_status;
          phase_nxt            = urs_pkg::PH_IDLE;
        end else if (expired(since_trigger_nxt, cfg_i.echo_wait_limit)) begin
          res_o.done_res = 1'b1;
          res_o.status   = urs_pkg::ST_TIMEOUT;
          phase_nxt      = urs_pkg::PH_IDLE;
        end
      end
      default: phase_nxt = urs_pkg::PH_IDLE;
    endcase

    res_o.busy_res = (phase_nxt != urs_pkg::PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= urs_pkg::PH_IDLE;
      phase_timer_r   <= '0;
      since_trigger_r <= '0;
      width_count_r   <= '0;
      echo_seen_r     <= 1'b0;
    end else if (step_i) begin
      phase_r         <= phase_nxt;
      phase_timer_r   <= phase_timer_nxt;
      since_trigger_r <= since_trigger_nxt;
      width_count_r   <= width_count_nxt;
      echo_seen_r     <= echo_seen_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/ultrasonic_ranging_sequencer.sv =====
// Ultrasonic ranging sequencer, top level: input register, step core,
// result register and configuration registers. Depends on urs_pkg,
// urs_regs and urs_core.
//
// Usage: each transfer on the in_ channel is one microsecond tick of pin
// sampling (start request and echo level). Every input transfer yields
// exactly one result transfer on the out_ channel, carrying the trigger
// level to drive, busy and done flags, status, pulse width and distance.
// Throughput is one tick per clock cycle while out_tready stays high;
// the phase machine and its counters advance once per tick in a single
// pass between the input register and the result register, which
// drives out_tvalid. A stall on out_tready holds the result; the input
// register still takes one more tick, after which in_tready drops
// until the result is taken, so nothing is lost or repeated.
// Configuration goes through the cfg_ APB-style port, registers at byte
// address 4*i; writes are meant for when the sequencer is idle.
// Reset (rst_n low, synchronous) empties both registers, returns the
// sequencer to idle with cleared counters and loads default settings.
`default_nettype none
module ultrasonic_ranging_sequencer #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  // in_tdata: [0] start_req, [1] echo_level, [7:2] zero
  input  wire logic [7:0]                 in_tdata,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  // out_tdata: [0] trigger_level, [1] busy_res, [2] done_res, [5:3] status,
  // [21:6] pulse_width_us, [37:22] distance_q4, [39:38] zero
  output logic      [39:0]                out_tdata,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [urs_pkg::ADDR_W-1:0] cfg_paddr,
  input  wire logic [urs_pkg::DATA_W-1:0] cfg_pwdata,
  output logic      [urs_pkg::DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);

  urs_pkg::cfg_t cfg;
  urs_pkg::res_t res;
  urs_pkg::res_t res_r;

  logic in_valid_r, in_valid_nxt;
  logic start_r;
  logic echo_r;
  logic out_valid_r, out_valid_nxt;
  logic out_free;
  logic step;
  logic in_xfer;

  urs_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg_o   (cfg)
  );

  urs_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_i  (step),
    .start_i (start_r),
    .echo_i  (echo_r),
    .cfg_i   (cfg),
    .res_o   (res)
  );

  assign out_free  = !out_valid_r || out_tready;
  assign step      = in_valid_r && out_free;
  assign in_tready = !in_valid_r || step;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_xfer) begin
      in_valid_nxt = 1'b1;
    end else if (step) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      start_r <= in_tdata[0];
      echo_r  <= in_tdata[1];
    end
    if (step) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, res_r.distance_q4, res_r.pulse_width_us, res_r.status,
                       res_r.done_res, res_r.busy_res, res_r.trigger_level};

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for ultrasonic_ranging_sequencer: pin ticks in, one result per tick.
// Needs urs_pkg and the RTL of the block; predicts every result and checks it field by field.
`timescale 1ns / 1ps
module tb;

  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam logic [15:0] CNT_TOP = 16'hFFFF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  // in_tdata: [0] start_req, [1] echo_level, [7:2] zero
  logic [7:0] in_tdata = 8'h00;
  logic out_tvalid;
  logic out_tready = 1'b0;
  // out_tdata: [0] trigger_level, [1] busy_res, [2] done_res, [5:3] status,
  // [21:6] pulse_width_us, [37:22] distance_q4, [39:38] zero
  logic [39:0] out_tdata;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [urs_pkg::ADDR_W-1:0] cfg_paddr = '0;
  logic [urs_pkg::DATA_W-1:0] cfg_pwdata = '0;
  logic [urs_pkg::DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  ultrasonic_ranging_sequencer DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Pin ticks waiting to be sent, {echo, start}, and results still owed by the block.
  logic [1:0] pin_ticks[$];
  urs_pkg::res_t pending_res[$];
  int unsigned ticks_queued = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  // Predicted sequencer state and its copy of the registers.
  urs_pkg::cfg_t cfg_mirror;
  urs_pkg::phase_t seq_phase = urs_pkg::PH_IDLE;
  logic [15:0] phase_timer = '0;
  logic [15:0] since_trig = '0;
  logic [15:0] width_cnt = '0;
  logic echo_seen = 1'b0;

  // Flow control between the stimulus thread and the two drivers.
  logic in_acc = 1'b0;
  logic tx_pause = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned rx_hold_req = 0;
  int unsigned rx_holds_done = 0;
  int unsigned rx_hold_left = 0;
  int unsigned rx_mode = 0;
  int unsigned rx_mode_left = 0;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == CNT_TOP) ? v : v + 16'd1;
  endfunction

  // A counter pinned at its top value counts as expired whatever the limit.
  function automatic logic timed_out(input logic [15:0] v, input logic [15:0] lim);
    return (v >= lim) || (v == CNT_TOP);
  endfunction

  function automatic urs_pkg::res_t advance_ranging(input logic start, input logic echo);
    urs_pkg::res_t r;
    logic [31:0] prod;
    r = '0;
    if (seq_phase == urs_pkg::PH_IDLE && start) begin
      seq_phase = urs_pkg::PH_WAIT_LOW;
      phase_timer = '0;
    end
    case (seq_phase)
      urs_pkg::PH_IDLE: ;
      urs_pkg::PH_WAIT_LOW: begin
        if (!echo) begin
          phase_timer = '0;
          seq_phase = (cfg_mirror.trigger_low_time != 8'd0) ? urs_pkg::PH_TRIG_LOW
                                                            : urs_pkg::PH_TRIG_HIGH;
        end else begin
          phase_timer = sat_inc(phase_timer);
          if (timed_out(phase_timer, cfg_mirror.echo_low_wait_limit)) begin
            r.done_res = 1'b1;
            r.status = urs_pkg::ST_STUCK;
            seq_phase = urs_pkg::PH_IDLE;
          end
        end
      end
      urs_pkg::PH_TRIG_LOW: begin
        phase_timer = sat_inc(phase_timer);
        if (timed_out(phase_timer, {8'h00, cfg_mirror.trigger_low_time})) begin
          phase_timer = '0;
          seq_phase = urs_pkg::PH_TRIG_HIGH;
        end
      end
      urs_pkg::PH_TRIG_HIGH: begin
        r.trigger_level = 1'b1;
        phase_timer = sat_inc(phase_timer);
        if (timed_out(phase_timer, {8'h00, cfg_mirror.trigger_high_time})) begin
          phase_timer = '0;
          since_trig = '0;
          width_cnt = '0;
          echo_seen = 1'b0;
          seq_phase = urs_pkg::PH_WAIT_ECHO;
        end
      end
      urs_pkg::PH_WAIT_ECHO: begin
        since_trig = sat_inc(since_trig);
        if (echo) begin
          echo_seen = 1'b1;
          width_cnt = sat_inc(width_cnt);
        end
        // The falling edge of the echo wins over a timeout on the same tick.
        if (!echo && echo_seen) begin
          prod = 32'(width_cnt) * 32'(cfg_mirror.sound_speed_q16);
          r.done_res = 1'b1;
          r.pulse_width_us = width_cnt;
          r.distance_q4 = (prod[31:29] != 3'b000) ? 16'hFFFF : prod[28:13];
          if (prod < {3'b000, cfg_mirror.min_range_cm, 17'h0})
            r.status = urs_pkg::ST_TOO_NEAR;
          else if (prod > {3'b000, cfg_mirror.max_range_cm, 17'h0})
            r.status = urs_pkg::ST_TOO_FAR;
          else
            r.status = urs_pkg::ST_OK;
          seq_phase = urs_pkg::PH_IDLE;
        end else if (timed_out(since_trig, cfg_mirror.echo_wait_limit)) begin
          r.done_res = 1'b1;
          r.status = urs_pkg::ST_TIMEOUT;
          seq_phase = urs_pkg::PH_IDLE;
        end
      end
      default: seq_phase = urs_pkg::PH_IDLE;
    endcase
    r.busy_res = (seq_phase != urs_pkg::PH_IDLE);
    return r;
  endfunction

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Checks results and records accepted ticks; the output side goes first so a
  // queue is never pushed and popped in an order that depends on the simulator.
  always @(posedge clk) begin
    urs_pkg::res_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_res.size() == 0) begin
          $display("%0t: result transfer with nothing pending, actual %h", $time, out_tdata);
          mismatches++;
        end else begin
          want = pending_res.pop_front();
          check_field("trigger_level", 32'(want.trigger_level), 32'(out_tdata[0]));
          check_field("busy_res", 32'(want.busy_res), 32'(out_tdata[1]));
          check_field("done_res", 32'(want.done_res), 32'(out_tdata[2]));
          check_field("status", 32'(want.status), 32'(out_tdata[5:3]));
          check_field("pulse_width_us", 32'(want.pulse_width_us), 32'(out_tdata[21:6]));
          check_field("distance_q4", 32'(want.distance_q4), 32'(out_tdata[37:22]));
        end
      end
      if (in_tvalid && in_tready) begin
        pending_res.push_back(advance_ranging(in_tdata[0], in_tdata[1]));
        void'(pin_ticks.pop_front());
      end
    end
    in_acc <= rst_n && in_tvalid && in_tready;
  end

  // Sender: bursts of ticks with gaps between them; a raised valid holds until taken.
  always @(negedge clk) begin
    logic go;
    go = 1'b0;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= 8'h00;
    end else if (!(in_tvalid && !in_acc)) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
      end else if (!tx_pause && pin_ticks.size() != 0) begin
        go = 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 48);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
      in_tvalid <= go;
      in_tdata <= go ? {6'b000000, pin_ticks[0]} : 8'h00;
    end
  end

  // Receiver: switches between always ready, mostly ready and mostly stalled,
  // and holds off for a long stretch when asked.
  always @(negedge clk) begin
    if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
      out_tready <= 1'b0;
    end else if (rx_holds_done != rx_hold_req) begin
      rx_holds_done <= rx_holds_done + 1;
      rx_hold_left <= 150;
      out_tready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode <= $urandom_range(0, 2);
        rx_mode_left <= $urandom_range(16, 128);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[ultrasonic_ranging_sequencer] ERROR");
      $finish;
    end
  end

  task automatic push_tick(input logic start, input logic echo);
    pin_ticks.push_back({echo, start});
    ticks_queued++;
  endtask

  task automatic push_ticks(input int unsigned n, input logic start, input logic echo);
    repeat (n) push_tick(start, echo);
  endtask

  task automatic push_noise(input int unsigned n);
    repeat (n) push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // One measurement: start with echo high for hi ticks, trigger-time noise,
  // a quiet stretch, the echo pulse and a low tail.
  task automatic push_measure(input int unsigned hi, input int unsigned trig,
                              input int unsigned lo, input int unsigned width,
                              input int unsigned tail);
    push_tick(1'b1, hi != 0);
    if (hi > 1) push_ticks(hi - 1, 1'b0, 1'b1);
    push_tick(1'b0, 1'b0);
    push_noise(trig);
    push_ticks(lo, 1'b0, 1'b0);
    push_ticks(width, 1'b0, 1'b1);
    push_ticks(tail, 1'b0, 1'b0);
  endtask

  task automatic queue_random_measurement();
    int unsigned hi, trig, width, ew, pick;
    ew = cfg_mirror.echo_wait_limit;
    push_ticks($urandom_range(0, 2), 1'b0, 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 9) == 0) begin
      push_noise($urandom_range(1, 20));
    end else begin
      hi = ($urandom_range(0, 3) == 0) ?
           $urandom_range(1, cfg_mirror.echo_low_wait_limit + 1) : 0;
      trig = cfg_mirror.trigger_low_time + cfg_mirror.trigger_high_time;
      pick = $urandom_range(0, 9);
      if (pick == 0)
        width = 0;
      else if (pick < 3)
        width = $urandom_range(1, ew + 2);
      else
        width = $urandom_range(1, (ew < 30) ? ew : 30);
      push_measure(hi, trig, $urandom_range(0, 3), width,
                   (width == 0) ? ew + 2 : $urandom_range(1, 3));
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pin_ticks.size() != 0 || in_tvalid || pending_res.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Lets any measurement still running finish, so the registers can be changed.
  task automatic settle();
    do begin
      wait_drained();
      if (seq_phase != urs_pkg::PH_IDLE) push_ticks(16, 1'b0, 1'b0);
    end while (seq_phase != urs_pkg::PH_IDLE);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      urs_pkg::REG_ECHO_LOW_WAIT: cfg_mirror.echo_low_wait_limit = val[15:0];
      urs_pkg::REG_TRIG_LOW:      cfg_mirror.trigger_low_time = val[7:0];
      urs_pkg::REG_TRIG_HIGH:     cfg_mirror.trigger_high_time = val[7:0];
      urs_pkg::REG_ECHO_WAIT:     cfg_mirror.echo_wait_limit = val[15:0];
      urs_pkg::REG_SOUND_SPEED:   cfg_mirror.sound_speed_q16 = val[15:0];
      urs_pkg::REG_MIN_RANGE:     cfg_mirror.min_range_cm = val[11:0];
      urs_pkg::REG_MAX_RANGE:     cfg_mirror.max_range_cm = val[11:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input int unsigned elw, input int unsigned tl,
                           input int unsigned th, input int unsigned ew,
                           input int unsigned speed, input int unsigned min_cm,
                           input int unsigned max_cm);
    write_reg(urs_pkg::REG_ECHO_LOW_WAIT, elw);
    write_reg(urs_pkg::REG_TRIG_LOW, tl);
    write_reg(urs_pkg::REG_TRIG_HIGH, th);
    write_reg(urs_pkg::REG_ECHO_WAIT, ew);
    write_reg(urs_pkg::REG_SOUND_SPEED, speed);
    write_reg(urs_pkg::REG_MIN_RANGE, min_cm);
    write_reg(urs_pkg::REG_MAX_RANGE, max_cm);
  endtask

  initial begin
    int unsigned phase_base;
    int unsigned half;
    int unsigned widths[5];
    widths = '{1, 4, 5, 6, 7};
    cfg_mirror.echo_low_wait_limit = 16'd30000;
    cfg_mirror.trigger_low_time = 8'd2;
    cfg_mirror.trigger_high_time = 8'd20;
    cfg_mirror.echo_wait_limit = 16'd30000;
    cfg_mirror.sound_speed_q16 = 16'd2248;
    cfg_mirror.min_range_cm = 12'd25;
    cfg_mirror.max_range_cm = 12'd450;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Settings after reset: an echo that is too near.
    push_ticks(3, 1'b0, 1'b1);
    push_ticks(2, 1'b0, 1'b0);
    push_measure(2, 22, 3, 40, 2);
    settle();

    // Short times: stuck echo, the limit edges, timeout and range edges.
    write_all(3, 0, 1, 10, 16'hFFFF, 2, 3);
    push_measure(3, 0, 0, 0, 2);
    push_measure(2, 0, 1, 0, 12);
    push_measure(0, 0, 0, 9, 2);
    push_measure(0, 0, 0, 10, 2);
    foreach (widths[i]) push_measure(0, 0, 0, widths[i], 1);
    // A start held high is ignored while running and restarts right after.
    push_measure(0, 0, 0, 0, 0);
    push_ticks(14, 1'b1, 1'b0);
    settle();

    // All limits and times zero.
    write_all(0, 0, 0, 0, 0, 0, 0);
    push_measure(1, 0, 0, 0, 2);
    push_measure(0, 0, 0, 1, 2);
    push_measure(0, 0, 0, 0, 2);
    settle();

    // Limits, speed and range at their top, with the longest trigger low time.
    write_all(16'hFFFF, 8'hFF, 8'd1, 16'hFFFF, 16'hFFFF, 12'hFFF, 12'hFFF);
    push_measure(0, 256, 2, 20, 2);
    settle();

    for (int p = 0; p < 6; p++) begin
      write_all($urandom_range(1, 12), $urandom_range(0, 4), $urandom_range(1, 4),
                $urandom_range(1, 50), $urandom_range(0, 16'hFFFF),
                $urandom_range(0, 12), $urandom_range(0, 25));
      phase_base = ticks_queued;
      for (int m = 0; m < 2 || ticks_queued < phase_base + 30; m++)
        queue_random_measurement();
      if (p == 0) begin
        // Long receiver hold while ticks keep coming, so the block backs up.
        rx_hold_req <= rx_hold_req + 1;
      end else if (p == 1) begin
        // Sender stops mid-phase until every result owed has arrived.
        half = pin_ticks.size() / 2;
        while (pin_ticks.size() > half) @(negedge clk);
        tx_pause <= 1'b1;
        do @(negedge clk);
        while (in_tvalid || pending_res.size() != 0);
        tx_pause <= 1'b0;
      end
      settle();
    end

    wait_drained();
    if (mismatches == 0 && pending_res.size() == 0) begin
      $display("[ultrasonic_ranging_sequencer] OK");
    end else begin
      $display("[ultrasonic_ranging_sequencer] ERROR");
    end
    $finish;
  end

endmodule
